// ===== hw/rtl/vbd_pkg.sv =====
// shared types and constants for the volume box downsampler
package vbd_pkg;

    localparam int unsigned DEF_MAX_SIZE_X = 256;
    localparam int unsigned DEF_MAX_SIZE_Y = 256;
    localparam int unsigned DEF_MAX_SIZE_Z = 256;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SUM_W    = 19;
    localparam int unsigned SIZE_W   = 9;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic                       mean_valid;
        logic                       frame_end;
        logic signed [SAMPLE_W-1:0] frame_min;
        logic signed [SAMPLE_W-1:0] frame_max;
    } result_t;

endpackage

// ===== hw/rtl/vbd_if.sv =====
// valid/ready channel interfaces
interface vbd_sample_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface vbd_result_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  mean_value;
    logic                mean_valid;
    logic                frame_end;
    logic signed [15:0]  frame_min;
    logic signed [15:0]  frame_max;
    modport source (output valid, output mean_value, output mean_valid, output frame_end,
                    output frame_min, output frame_max, input ready);
    modport sink   (input valid, input mean_value, input mean_valid, input frame_end,
                    input frame_min, input frame_max, output ready);
endinterface

interface vbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [8:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/vbd_front.sv =====
// front end: position tracking, cell classification, frame min and max
module vbd_front
    import vbd_pkg::*;
#(
    parameter int unsigned MAX_SIZE_X = DEF_MAX_SIZE_X,
    parameter int unsigned MAX_SIZE_Y = DEF_MAX_SIZE_Y,
    parameter int unsigned MAX_SIZE_Z = DEF_MAX_SIZE_Z,
    parameter int unsigned ADDR_W     = 14
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_fire,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       cfg_fire,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [SIZE_W-1:0]          cfg_data,
    output logic [ADDR_W-1:0]          op_addr,
    output logic                       op_first,
    output logic                       op_last,
    output logic                       op_fend,
    output logic signed [SAMPLE_W-1:0] op_min,
    output logic signed [SAMPLE_W-1:0] op_max
);
    localparam int unsigned PX_W = $clog2(MAX_SIZE_X + 1);
    localparam int unsigned PY_W = $clog2(MAX_SIZE_Y + 1);
    localparam int unsigned PZ_W = $clog2(MAX_SIZE_Z + 1);
    localparam int unsigned HALF_Z = MAX_SIZE_Z / 2;
    localparam int unsigned DEPTH = (MAX_SIZE_Y / 2) * (MAX_SIZE_Z / 2);
    localparam int unsigned EW = 13;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [PX_W-1:0] pos_x_reg, pos_x_next;
    logic [PY_W-1:0] pos_y_reg, pos_y_next;
    logic [PZ_W-1:0] pos_z_reg, pos_z_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next, max_reg, max_next;
    logic [EW-1:0] ex, ey, ez;
    logic [31:0] addr_full;

    function automatic logic [EW-1:0] clamp(input logic [SIZE_W-1:0] v, input int unsigned m);
        logic [EW-1:0] r;
        begin
            r = EW'(v);
            if (r < EW'(2))
                r = EW'(2);
            else if (r > EW'(m))
                r = EW'(m);
            return r;
        end
    endfunction

    always_comb
    begin
        ex = clamp(size_x_reg, MAX_SIZE_X);
        ey = clamp(size_y_reg, MAX_SIZE_Y);
        ez = clamp(size_z_reg, MAX_SIZE_Z);
        addr_full = 32'(pos_y_reg >> 1) * 32'(HALF_Z) + 32'(pos_z_reg >> 1);
        if (addr_full >= 32'(DEPTH))
            addr_full = '0;
        op_addr  = addr_full[ADDR_W-1:0];
        op_first = !(pos_x_reg[0] | pos_y_reg[0] | pos_z_reg[0]);
        op_last  = pos_x_reg[0] & pos_y_reg[0] & pos_z_reg[0];
        min_next = (in_sample < min_reg) ? in_sample : min_reg;
        max_next = (in_sample > max_reg) ? in_sample : max_reg;
        op_min   = min_next;
        op_max   = max_next;
        op_fend  = (EW'(pos_x_reg) + EW'(1) >= ex) && (EW'(pos_y_reg) + EW'(1) >= ey)
                && (EW'(pos_z_reg) + EW'(1) >= ez);
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg + PZ_W'(1);
        if (op_fend)
        begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
        end
        else if (EW'(pos_z_next) >= ez)
        begin
            pos_z_next = '0;
            pos_y_next = pos_y_reg + PY_W'(1);
            if (EW'(pos_y_next) >= ey)
            begin
                pos_y_next = '0;
                pos_x_next = pos_x_reg + PX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            min_reg    <= SAMPLE_MAX;
            max_reg    <= SAMPLE_MIN;
        end
        else if (cfg_fire)
        begin
            if (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y || cfg_index == REG_SIZE_Z)
            begin
                case (cfg_index)
                    REG_SIZE_X: size_x_reg <= cfg_data;
                    REG_SIZE_Y: size_y_reg <= cfg_data;
                    default:    size_z_reg <= cfg_data;
                endcase
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
                min_reg   <= SAMPLE_MAX;
                max_reg   <= SAMPLE_MIN;
            end
        end
        else if (in_fire)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            min_reg   <= op_fend ? SAMPLE_MAX : min_next;
            max_reg   <= op_fend ? SAMPLE_MIN : max_next;
        end
    end
endmodule

// ===== hw/rtl/vbd_back.sv =====
// back end: partial sum memory read-modify-write, mean and result queue
module vbd_back
    import vbd_pkg::*;
#(
    parameter int unsigned ADDR_W = 14,
    parameter int unsigned DEPTH  = 16384
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       op_valid,
    input  logic [ADDR_W-1:0]          op_addr,
    input  logic                       op_first,
    input  logic                       op_last,
    input  logic                       op_fend,
    input  logic signed [SAMPLE_W-1:0] op_sample,
    input  logic signed [SAMPLE_W-1:0] op_min,
    input  logic signed [SAMPLE_W-1:0] op_max,
    output logic                       room,
    output logic                       res_valid,
    input  logic                       res_ready,
    output result_t                    res_data
);
    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_reg;
    logic             s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic             s1_first_reg, s1_last_reg, s1_fend_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg, s1_min_reg, s1_max_reg;
    logic             byp_valid_reg;
    logic [ADDR_W-1:0] byp_addr_reg;
    logic [SUM_W-1:0] byp_sum_reg;
    logic [SUM_W-1:0] old_sum, new_sum;
    result_t          s1_res;
    logic             s1_emit;

    result_t q_data [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       push, pop;

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[op_addr];
        if (s1_valid_reg)
            mem[s1_addr_reg] <= new_sum;
    end

    always_comb
    begin
        old_sum = (s1_valid_reg && byp_valid_reg && byp_addr_reg == s1_addr_reg)
                ? byp_sum_reg : rd_reg;
        new_sum = s1_first_reg ? SUM_W'(s1_sample_reg)
                               : old_sum + SUM_W'(s1_sample_reg);
        s1_res.mean_value = s1_last_reg ? new_sum[SUM_W-1:3] : '0;
        s1_res.mean_valid = s1_last_reg;
        s1_res.frame_end  = s1_fend_reg;
        s1_res.frame_min  = s1_fend_reg ? s1_min_reg : '0;
        s1_res.frame_max  = s1_fend_reg ? s1_max_reg : '0;
        s1_emit = s1_valid_reg && (s1_last_reg || s1_fend_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg   <= op_addr;
        s1_first_reg  <= op_first;
        s1_last_reg   <= op_last;
        s1_fend_reg   <= op_fend;
        s1_sample_reg <= op_sample;
        s1_min_reg    <= op_min;
        s1_max_reg    <= op_max;
        byp_addr_reg  <= s1_addr_reg;
        byp_sum_reg   <= new_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= op_valid;
            byp_valid_reg <= s1_valid_reg;
        end
    end

    // input held once queued results plus the item in flight reach three
    assign push      = s1_emit;
    assign pop       = res_valid && res_ready;
    assign res_valid = count_reg != 3'd0;
    assign res_data  = q_data[rd_ptr_reg];
    assign room      = (count_reg + 3'(s1_valid_reg)) < 3'd3;

    always_ff @(posedge clk)
    begin
        if (push)
            q_data[wr_ptr_reg] <= s1_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

// ===== hw/rtl/volume_box_downsampler.sv =====
// Volume 2x2x2 box-mean downsampler. One Q8.8 sample is taken per clock in raster order
// (z fastest, then y, then x); each completed cell yields its mean (sum >> 3), and the
// frame's last voxel also carries the frame minimum and maximum. Sustained rate is one
// item per cycle, set by the read-modify-write of the plane sum memory (one read and one
// write port), whose write-back is forwarded to the next item. A result is registered in
// stage one, then in the four-entry result queue; input stalls only when the results waiting
// in the queue plus the one in flight reach three, and while a register write waits.
module volume_box_downsampler
    import vbd_pkg::*;
#(
    parameter int unsigned MAX_SIZE_X = DEF_MAX_SIZE_X,
    parameter int unsigned MAX_SIZE_Y = DEF_MAX_SIZE_Y,
    parameter int unsigned MAX_SIZE_Z = DEF_MAX_SIZE_Z
)
(
    input  logic       clk,
    input  logic       rst_n,
    vbd_sample_if.sink in_ch,
    vbd_result_if.source out_ch,
    vbd_cfg_if.sink    cfg
);
    localparam int unsigned DEPTH  = (MAX_SIZE_Y / 2) * (MAX_SIZE_Z / 2);
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic in_fire, room;
    logic [ADDR_W-1:0] op_addr;
    logic op_first, op_last, op_fend;
    logic signed [SAMPLE_W-1:0] op_min, op_max;
    result_t res;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = room && !cfg.valid;
    assign in_fire     = in_ch.valid && in_ch.ready;

    vbd_front #(
        .MAX_SIZE_X(MAX_SIZE_X), .MAX_SIZE_Y(MAX_SIZE_Y), .MAX_SIZE_Z(MAX_SIZE_Z),
        .ADDR_W(ADDR_W)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_fire(in_fire), .in_sample(in_ch.sample),
        .cfg_fire(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
        .op_addr(op_addr), .op_first(op_first), .op_last(op_last), .op_fend(op_fend),
        .op_min(op_min), .op_max(op_max)
    );

    vbd_back #(.ADDR_W(ADDR_W), .DEPTH(DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .op_valid(in_fire), .op_addr(op_addr), .op_first(op_first), .op_last(op_last),
        .op_fend(op_fend), .op_sample(in_ch.sample), .op_min(op_min), .op_max(op_max),
        .room(room), .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(res)
    );

    assign out_ch.mean_value = res.mean_value;
    assign out_ch.mean_valid = res.mean_valid;
    assign out_ch.frame_end  = res.frame_end;
    assign out_ch.frame_min  = res.frame_min;
    assign out_ch.frame_max  = res.frame_max;
endmodule

// ===== hw/rtl/vbd_checker.sv =====
// port-level assertions for the downsampler
module vbd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       mean_valid,
    input logic       frame_end,
    input logic [15:0] mean_value,
    input logic [15:0] frame_min,
    input logic [15:0] frame_max
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_value))
        else $error("result dropped while stalled");
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mean_valid || frame_end)
        else $error("empty result");
    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mean_valid |-> mean_value == 16'd0)
        else $error("mean not zero");
    a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> $signed(frame_min) <= $signed(frame_max))
        else $error("min above max");
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) ##1 !(in_valid && in_ready) ##1 !(in_valid && in_ready)
        |-> !$rose(out_valid))
        else $error("result without item");
endmodule

bind volume_box_downsampler vbd_checker u_vbd_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .mean_valid(out_ch.mean_valid), .frame_end(out_ch.frame_end),
    .mean_value(out_ch.mean_value), .frame_min(out_ch.frame_min),
    .frame_max(out_ch.frame_max)
);
